// ===== rtl/ssf_pkg.sv =====
// Shared types, register indexes and saturation helpers for the stick-slip friction core.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ssf_pkg;

    // Field and datapath widths.
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned LOAD_W    = 31;
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned PROD_W    = 2 * DATA_W;
    localparam int unsigned RAD_W     = DATA_W + FRAC_W;
    localparam int unsigned ROOT_W    = RAD_W / 2;
    localparam int unsigned THR_W     = PROD_W - FRAC_W;
    localparam int unsigned K_W       = 42;
    localparam int unsigned KH_W      = K_W - DATA_W;
    localparam int unsigned MAG_W     = K_W + DATA_W - FRAC_W;
    localparam int unsigned CFG_IDX_W = 8;

    // Spring stiffness per square root of load.
    localparam logic [17:0] SPRING_ROOT = 18'd197990;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_COEFF   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DYNAMIC_COEFF  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_TIME     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP      = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_MASS       = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_NORMAL   = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_USE_FIXED      = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_ANCHOR = 8'd7;

    // Input word: one simulation step.
    typedef struct packed {
        logic signed [DATA_W-1:0] position;
        logic signed [DATA_W-1:0] velocity;
        logic        [LOAD_W-1:0] normal_load;
    } ssf_in_t;

    // Result word.
    typedef struct packed {
        logic signed [DATA_W-1:0] friction_force;
        logic                     stuck_now;
    } ssf_out_t;

    // Magnitude of a sign-magnitude value after saturation to the signed 32-bit range.
    function automatic logic [DATA_W-1:0] sat_mag(input logic neg,
                                                  input logic [MAG_W-1:0] mag);
        logic over;
        over = |mag[MAG_W-1:DATA_W-1];
        if (neg) begin
            return over ? {1'b1, {(DATA_W-1){1'b0}}} : mag[DATA_W-1:0];
        end
        return over ? {1'b0, {(DATA_W-1){1'b1}}} : mag[DATA_W-1:0];
    endfunction

    // Sign-magnitude value saturated to a signed 32-bit word.
    function automatic logic signed [DATA_W-1:0] sat_sm(input logic neg,
                                                        input logic [MAG_W-1:0] mag);
        logic [DATA_W-1:0] m;
        m = sat_mag(neg, mag);
        return neg ? (~m + 1'b1) : m;
    endfunction

    // Saturating signed 32-bit add.
    function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        logic [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return s[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ssf_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on ssf_pkg for the operand and product widths.
`timescale 1ns / 1ps
`default_nettype none

module ssf_mul
    import ssf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic [DATA_W-1:0] op_a,
    input  wire logic [DATA_W-1:0] op_b,
    output logic      [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    // One product per cycle; the sequencer reads it in the following cycle.
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/ssf_sqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on ssf_pkg for the radicand and root widths.
`timescale 1ns / 1ps
`default_nettype none

module ssf_sqrt
    import ssf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic                   done,
    output logic      [ROOT_W-1:0] root
);

    localparam int unsigned ITER  = RAD_W / 2;
    localparam int unsigned CNT_W = $clog2(ITER + 1);
    localparam int unsigned REM_W = ROOT_W + 2;
    localparam int unsigned TRY_W = REM_W + 2;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [RAD_W-1:0]  rad_reg;

    logic [TRY_W-1:0]  rem_sh;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  diff;
    logic              ge;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // Bring down the next two radicand bits and try to subtract 4*root+1.
    always_comb begin
        rem_sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        diff      = rem_sh - trial;
        ge        = (rem_sh >= trial);
        rem_next  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_next = {root_reg[ROOT_W-2:0], ge};
    end

    // Control: iteration count and completion flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(ITER);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: partial remainder, partial root and remaining radicand bits.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            root_reg <= '0;
            rad_reg  <= radicand;
        end else if (busy_reg) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== rtl/stick_slip_friction_step_core.sv =====
// Stick-slip friction step: a word that slides takes the longer path through the velocity and
// position updates, and every word may wait for the result register before it is handed on.
// Each word runs through the 24-step square-root loop and a chain of multiplies that all go
// through one shared 32x32 multiplier; one word is worked on at a time.
// Synchronous active-low reset clears the configuration, connector and control registers, sets the
// block stuck, anchor at zero. Depends on ssf_pkg, ssf_mul and ssf_sqrt.
`timescale 1ns / 1ps
`default_nettype none

module stick_slip_friction_step_core
    import ssf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire ssf_in_t              s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output ssf_out_t                  m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_THR  = 4'd1;
    localparam logic [3:0] S_DYN  = 4'd2;
    localparam logic [3:0] S_DYNR = 4'd3;
    localparam logic [3:0] S_WSQ  = 4'd4;
    localparam logic [3:0] S_KLO  = 4'd5;
    localparam logic [3:0] S_KHI  = 4'd6;
    localparam logic [3:0] S_SM   = 4'd7;
    localparam logic [3:0] S_CMP  = 4'd8;
    localparam logic [3:0] S_DV   = 4'd9;
    localparam logic [3:0] S_DVM  = 4'd10;
    localparam logic [3:0] S_VEL  = 4'd11;
    localparam logic [3:0] S_VABS = 4'd12;
    localparam logic [3:0] S_DPM  = 4'd13;
    localparam logic [3:0] S_POS  = 4'd14;
    localparam logic [3:0] S_OUT  = 4'd15;

    localparam int unsigned SUM_W = MAG_W + FRAC_W;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Configuration registers.
    logic [DATA_W-1:0] static_coeff_reg;
    logic [DATA_W-1:0] dynamic_coeff_reg;
    logic [DATA_W-1:0] stick_time_reg;
    logic [DATA_W-1:0] time_step_reg;
    logic [DATA_W-1:0] inv_mass_reg;
    logic [DATA_W-1:0] fixed_normal_reg;
    logic              use_fixed_reg;

    // Connector state.
    logic                     stuck_reg;
    logic signed [DATA_W-1:0] anchor_pos_reg;
    logic signed [DATA_W-1:0] anchor_vel_reg;
    logic        [DATA_W-1:0] melt_reg;

    // Per-word working registers.
    logic signed [DATA_W-1:0] pos_reg;
    logic                     vel_pos_reg;
    logic                     vel_zero_reg;
    logic        [DATA_W-1:0] ld_reg;
    logic        [DATA_W-1:0] adx_reg;
    logic                     dx_neg_reg;
    logic        [THR_W-1:0]  thr_reg;
    logic signed [DATA_W-1:0] dyn_reg;
    logic        [DATA_W-1:0] dyn_mag_reg;
    logic                     dyn_neg_reg;
    logic        [KH_W-1:0]   kh_reg;
    logic        [PROD_W-1:0] lo_reg;
    logic        [MAG_W-1:0]  smag_reg;
    logic        [DATA_W-1:0] mag_reg;
    logic                     neg_reg;
    logic signed [DATA_W-1:0] force_reg;

    // Result register.
    logic     m_valid_reg;
    ssf_out_t m_data_reg;

    // Shared units.
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;
    logic              sq_start;
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;

    // Combinational helpers.
    logic                     in_accept;
    logic                     out_free;
    logic                     slide;
    logic                     spring_wins;
    logic signed [DATA_W-1:0] spring;
    logic        [THR_W-1:0]  prod_hi;
    logic        [DATA_W:0]   dx;
    logic        [DATA_W:0]   dx_abs;
    logic        [SUM_W-1:0]  smag_sum;
    logic        [DATA_W-1:0] dmag_sat;
    logic        [DATA_W:0]   melt_sum;
    logic        [DATA_W-1:0] vel_abs;
    logic signed [DATA_W-1:0] step_delta;

    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    ssf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    assign sq_start = (state_reg == S_THR);

    ssf_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand ({ld_reg, {FRAC_W{1'b0}}}),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Datapath helpers shared by several states.
    always_comb begin
        prod_hi     = mul_p[PROD_W-1:FRAC_W];
        dx          = {pos_reg[DATA_W-1], pos_reg} - {anchor_pos_reg[DATA_W-1], anchor_pos_reg};
        dx_abs      = dx[DATA_W] ? (~dx + 1'b1) : dx;
        smag_sum    = {mul_p[K_W-1:0], {DATA_W{1'b0}}} + SUM_W'(lo_reg);
        dmag_sat    = vel_zero_reg ? '0 : sat_mag(vel_pos_reg, MAG_W'(prod_hi));
        spring      = sat_sm(!dx_neg_reg, smag_reg);
        spring_wins = (smag_reg < MAG_W'(thr_reg));
        slide       = !stuck_reg && (melt_reg < stick_time_reg);
        melt_sum    = {1'b0, melt_reg} + {1'b0, time_step_reg};
        vel_abs     = anchor_vel_reg[DATA_W-1] ? (~anchor_vel_reg + 1'b1) : anchor_vel_reg;
        step_delta  = sat_sm(neg_reg, MAG_W'(prod_hi));
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (state_reg) inside
            S_THR: begin
                mul_a = static_coeff_reg;
                mul_b = ld_reg;
            end
            S_DYN: begin
                mul_a = dynamic_coeff_reg;
                mul_b = ld_reg;
            end
            S_WSQ: begin
                mul_a = DATA_W'(SPRING_ROOT);
                mul_b = DATA_W'(sq_root);
            end
            S_KLO: begin
                mul_a = mul_p[DATA_W-1:0];
                mul_b = adx_reg;
            end
            S_KHI: begin
                mul_a = DATA_W'(kh_reg);
                mul_b = adx_reg;
            end
            S_CMP: begin
                mul_a = dyn_mag_reg;
                mul_b = inv_mass_reg;
            end
            S_DVM, S_DPM: begin
                mul_a = mag_reg;
                mul_b = time_step_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        unique case (state_reg)
            S_IDLE:  state_next = in_accept ? S_THR : S_IDLE;
            S_THR:   state_next = S_DYN;
            S_DYN:   state_next = S_DYNR;
            S_DYNR:  state_next = S_WSQ;
            S_WSQ:   state_next = sq_done ? S_KLO : S_WSQ;
            S_KLO:   state_next = S_KHI;
            S_KHI:   state_next = S_SM;
            S_SM:    state_next = S_CMP;
            S_CMP:   state_next = slide ? S_DV : S_OUT;
            S_DV:    state_next = S_DVM;
            S_DVM:   state_next = S_VEL;
            S_VEL:   state_next = S_VABS;
            S_VABS:  state_next = S_DPM;
            S_DPM:   state_next = S_POS;
            S_POS:   state_next = S_OUT;
            S_OUT:   state_next = out_free ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers and connector state; a write to the initial anchor also
    // moves the anchor itself.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            static_coeff_reg  <= '0;
            dynamic_coeff_reg <= '0;
            stick_time_reg    <= '0;
            time_step_reg     <= '0;
            inv_mass_reg      <= '0;
            fixed_normal_reg  <= '0;
            use_fixed_reg     <= 1'b0;
            stuck_reg         <= 1'b1;
            anchor_pos_reg    <= '0;
            anchor_vel_reg    <= '0;
            melt_reg          <= '0;
        end else begin
            if (state_reg == S_CMP) begin
                if (stuck_reg) begin
                    if (!spring_wins) begin
                        stuck_reg <= 1'b0;
                    end
                end else if (slide) begin
                    melt_reg <= melt_sum[DATA_W] ? '1 : melt_sum[DATA_W-1:0];
                end else begin
                    melt_reg       <= '0;
                    anchor_pos_reg <= pos_reg;
                    stuck_reg      <= 1'b1;
                end
            end
            if (state_reg == S_VEL) begin
                anchor_vel_reg <= sat_add(anchor_vel_reg, step_delta);
            end
            if (state_reg == S_POS) begin
                anchor_pos_reg <= sat_add(anchor_pos_reg, step_delta);
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_STATIC_COEFF:   static_coeff_reg  <= cfg_data;
                    REG_DYNAMIC_COEFF:  dynamic_coeff_reg <= cfg_data;
                    REG_STICK_TIME:     stick_time_reg    <= cfg_data;
                    REG_TIME_STEP:      time_step_reg     <= cfg_data;
                    REG_INV_MASS:       inv_mass_reg      <= cfg_data;
                    REG_FIXED_NORMAL:   fixed_normal_reg  <= cfg_data;
                    REG_USE_FIXED:      use_fixed_reg     <= cfg_data[0];
                    REG_INITIAL_ANCHOR: anchor_pos_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Per-word working registers, loaded as the sequencer walks through the steps.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    pos_reg      <= s_data.position;
                    vel_pos_reg  <= !s_data.velocity[DATA_W-1] && (|s_data.velocity);
                    vel_zero_reg <= !(|s_data.velocity);
                    ld_reg       <= use_fixed_reg ? fixed_normal_reg
                                                  : {1'b0, s_data.normal_load};
                end
            end
            S_THR: begin
                adx_reg    <= dx_abs[DATA_W-1:0];
                dx_neg_reg <= dx[DATA_W];
            end
            S_DYN: begin
                thr_reg <= prod_hi;
            end
            S_DYNR: begin
                dyn_mag_reg <= dmag_sat;
                dyn_neg_reg <= vel_pos_reg;
                dyn_reg     <= vel_pos_reg ? (~dmag_sat + 1'b1) : dmag_sat;
            end
            S_KLO: begin
                kh_reg <= mul_p[K_W-1:DATA_W];
            end
            S_KHI: begin
                lo_reg <= mul_p;
            end
            S_SM: begin
                smag_reg <= smag_sum[SUM_W-1:FRAC_W];
            end
            S_CMP: begin
                if (stuck_reg) begin
                    force_reg <= spring_wins ? spring : dyn_reg;
                end else begin
                    force_reg <= slide ? dyn_reg : spring;
                end
            end
            S_DV: begin
                mag_reg <= sat_mag(dyn_neg_reg, MAG_W'(prod_hi));
                neg_reg <= dyn_neg_reg;
            end
            S_VABS: begin
                mag_reg <= vel_abs;
                neg_reg <= anchor_vel_reg[DATA_W-1];
            end
            default: ;
        endcase
    end

    // Result register: holds a finished word until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_data_reg.friction_force <= force_reg;
            m_data_reg.stuck_now      <= stuck_reg;
        end
    end

endmodule

`default_nettype wire
